/* rtl/core/qrs_pkg.sv */
package qrs_pkg;

	localparam int OUT_W  = 34;
	localparam int KIND_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_EQUAL    = 2'd0,
		KIND_DISTINCT = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_A_ZERO   = 2'd3
	} kind_t;

endpackage

/* rtl/core/quadratic_root_solver.sv */
// Solves a*x^2 + b*x + c for one coefficient triple per transaction and returns
// both roots as complex values with FRAC_BITS fraction bits, saturated to 34 bits,
// with a kind code on m_tuser. The block takes one transaction every cycle while
// the master side is not stalling. The pipeline is made of the bit-per-stage
// square root (COEFF_WIDTH+1 stages) and the bit-per-stage dividers
// (COEFF_WIDTH+FRAC_BITS+2 stages), plus two multiply/discriminant stages, one
// operand select stage and the output register. A stall on the master side holds
// the whole pipeline; nothing is lost.
module quadratic_root_solver #(
	parameter int COEFF_WIDTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// coeff_a, coeff_b, coeff_c
	input  logic [((3*COEFF_WIDTH+7)/8)*8-1:0]         s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// first_real, first_imag, second_real, second_imag
	output logic [4*qrs_pkg::OUT_W-1:0]                m_tdata,
	// root_kind
	output logic [qrs_pkg::KIND_W-1:0]                 m_tuser
);

	localparam int CW  = COEFF_WIDTH;
	localparam int OW  = qrs_pkg::OUT_W;
	localparam int VW  = 2*CW + 2;
	localparam int RW  = CW + 1;
	localparam int NMW = CW + 3;
	localparam int NW  = CW + 2 + FRAC_BITS;
	localparam int DW  = CW + 1;
	localparam int QX  = (NW > OW + 1) ? NW : OW + 1;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		qrs_pkg::kind_t       kind;
		logic [VW-1:0]        v;
		logic [RW+1:0]        rem;
		logic [RW-1:0]        root;
	} sq_t;

	typedef struct packed {
		qrs_pkg::kind_t       kind;
		logic [DW-1:0]        dvs;
		logic [2:0][DW-1:0]   rem;
		logic [2:0][NW-1:0]   dvd;
		logic [2:0]           neg;
	} dv_t;

	function automatic logic [OW-1:0] sat(input logic [NW-1:0] q, input logic neg);
		logic [QX-1:0] m;
		logic [QX-1:0] hi;
		m  = QX'(q);
		hi = QX'({(OW-1){1'b1}});
		if (!neg)
			return (m > hi) ? OW'(hi) : OW'(m);
		else
			return (m > hi + QX'(1)) ? {1'b1, {(OW-1){1'b0}}} : OW'(-m);
	endfunction

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic signed [CW-1:0]   in_a, in_b, in_c;
	logic signed [2*CW-1:0] ac_c, bb_c;
	assign in_a = s_tdata[CW-1:0];
	assign in_b = s_tdata[2*CW-1:CW];
	assign in_c = s_tdata[3*CW-1:2*CW];
	assign ac_c = in_a * in_c;
	assign bb_c = in_b * in_b;

	logic                   v_s1;
	logic signed [CW-1:0]   a_s1, b_s1;
	logic signed [2*CW-1:0] ac_s1;
	logic [2*CW-1:0]        bb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= in_a;
			b_s1  <= in_b;
			ac_s1 <= ac_c;
			bb_s1 <= bb_c;
		end
	end

	logic signed [VW-1:0] d_c;
	logic [VW-1:0]        dmag_c;
	qrs_pkg::kind_t       kind_c;

	assign d_c    = $signed({2'b00, bb_s1}) - ($signed({{2{ac_s1[2*CW-1]}}, ac_s1}) <<< 2);
	assign dmag_c = d_c[VW-1] ? VW'(-d_c) : VW'(d_c);

	always_comb begin
		if (a_s1 == '0)
			kind_c = qrs_pkg::KIND_A_ZERO;
		else if (d_c == '0)
			kind_c = qrs_pkg::KIND_EQUAL;
		else if (d_c[VW-1])
			kind_c = qrs_pkg::KIND_COMPLEX;
		else
			kind_c = qrs_pkg::KIND_DISTINCT;
	end

	sq_t        sq_s [0:RW];
	logic [RW:0] sqv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sqv_s[0] <= 1'b0;
		else if (adv)
			sqv_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].a    <= a_s1;
			sq_s[0].b    <= b_s1;
			sq_s[0].kind <= kind_c;
			sq_s[0].v    <= dmag_c;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RW+1:0] rem2, trial;
		logic          ge;
		sq_t           nxt;

		assign rem2  = {sq_s[j].rem[RW-1:0], sq_s[j].v[VW-1 -: 2]};
		assign trial = {sq_s[j].root, 2'b01};
		assign ge    = rem2 >= trial;

		always_comb begin
			nxt      = sq_s[j];
			nxt.v    = {sq_s[j].v[VW-3:0], 2'b00};
			nxt.rem  = ge ? rem2 - trial : rem2;
			nxt.root = {sq_s[j].root[RW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[j+1] <= 1'b0;
			else if (adv)
				sqv_s[j+1] <= sqv_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv)
				sq_s[j+1] <= nxt;
		end
	end

	logic signed [NMW-1:0] nb_c, s_c;
	logic signed [NMW-1:0] num_c [3];
	logic [CW-1:0]         amag_c;
	dv_t                   sel_c;

	assign nb_c   = -NMW'(sq_s[RW].b);
	assign s_c    = $signed(NMW'(sq_s[RW].root));
	assign amag_c = sq_s[RW].a[CW-1] ? CW'(-sq_s[RW].a) : CW'(sq_s[RW].a);

	always_comb begin
		num_c[0] = nb_c;
		num_c[1] = nb_c;
		num_c[2] = '0;
		if (sq_s[RW].kind == qrs_pkg::KIND_DISTINCT) begin
			num_c[0] = nb_c + s_c;
			num_c[1] = nb_c - s_c;
		end else if (sq_s[RW].kind == qrs_pkg::KIND_COMPLEX) begin
			num_c[2] = s_c;
		end
		sel_c.kind = sq_s[RW].kind;
		sel_c.dvs  = {amag_c, 1'b0};
		for (int i = 0; i < 3; i++) begin
			sel_c.rem[i] = '0;
			sel_c.neg[i] = num_c[i][NMW-1] ^ sq_s[RW].a[CW-1];
			sel_c.dvd[i] = num_c[i][NMW-1] ?
				{NW'(-num_c[i]) << FRAC_BITS} : {NW'(num_c[i]) << FRAC_BITS};
		end
	end

	dv_t         dv_s [0:NW];
	logic [NW:0] dvv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvv_s[0] <= 1'b0;
		else if (adv)
			dvv_s[0] <= sqv_s[RW];
	end

	always_ff @(posedge clk) begin
		if (adv)
			dv_s[0] <= sel_c;
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		dv_t nxt;

		always_comb begin
			logic [DW:0] t;
			logic        ge;
			nxt = dv_s[k];
			for (int i = 0; i < 3; i++) begin
				t   = {dv_s[k].rem[i], dv_s[k].dvd[i][NW-1]};
				ge  = t >= {1'b0, dv_s[k].dvs};
				nxt.rem[i] = ge ? DW'(t - {1'b0, dv_s[k].dvs}) : t[DW-1:0];
				nxt.dvd[i] = {dv_s[k].dvd[i][NW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvv_s[k+1] <= 1'b0;
			else if (adv)
				dvv_s[k+1] <= dvv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv)
				dv_s[k+1] <= nxt;
		end
	end

	logic [OW-1:0] fr_c, fi_c, sr_c, si_c;

	always_comb begin
		fr_c = sat(dv_s[NW].dvd[0], dv_s[NW].neg[0]);
		sr_c = sat(dv_s[NW].dvd[1], dv_s[NW].neg[1]);
		fi_c = sat(dv_s[NW].dvd[2], dv_s[NW].neg[2]);
		si_c = sat(dv_s[NW].dvd[2], !dv_s[NW].neg[2]);
		if (dv_s[NW].kind == qrs_pkg::KIND_A_ZERO) begin
			fr_c = '0;
			sr_c = '0;
			fi_c = '0;
			si_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv)
			m_tvalid <= dvv_s[NW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {si_c, sr_c, fi_c, fr_c};
			m_tuser <= dv_s[NW].kind;
		end
	end

endmodule

/* rtl/core/qrs_checker.sv */
module qrs_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [4*qrs_pkg::OUT_W-1:0]         m_tdata,
	input logic [qrs_pkg::KIND_W-1:0]          m_tuser
);

	localparam int OW = qrs_pkg::OUT_W;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled transaction changed");

	a_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == qrs_pkg::KIND_A_ZERO |-> m_tdata == '0)
		else $error("nonzero roots for zero a");

	a_real_imag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == qrs_pkg::KIND_EQUAL || m_tuser == qrs_pkg::KIND_DISTINCT)
		|-> m_tdata[2*OW-1:OW] == '0 && m_tdata[4*OW-1:3*OW] == '0)
		else $error("imaginary part on real roots");

	a_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == qrs_pkg::KIND_EQUAL |-> m_tdata[OW-1:0] == m_tdata[3*OW-1:2*OW])
		else $error("equal roots differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* test/tb_quadratic_root_solver.sv */
module tb_quadratic_root_solver;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int FB = 16;
	localparam int IN_W = ((3*CW+7)/8)*8;
	localparam int LATENCY = 2*CW + FB + 7;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] a;
	} coeffs_t;

	typedef struct {
		logic signed [qrs_pkg::OUT_W-1:0] first_real;
		logic signed [qrs_pkg::OUT_W-1:0] first_imag;
		logic signed [qrs_pkg::OUT_W-1:0] second_real;
		logic signed [qrs_pkg::OUT_W-1:0] second_imag;
		qrs_pkg::kind_t kind;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [4*qrs_pkg::OUT_W-1:0] m_tdata;
	logic [qrs_pkg::KIND_W-1:0] m_tuser;

	quadratic_root_solver #(.COEFF_WIDTH(CW), .FRAC_BITS(FB)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	coeffs_t pending_coeffs[$];
	roots_t expected_roots[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	bit in_taken = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;

	function automatic logic signed [qrs_pkg::OUT_W-1:0] clamp_out(longint v);
		longint hi;
		hi = (64'sd1 <<< (qrs_pkg::OUT_W-1)) - 1;
		if (v > hi)
			return hi[qrs_pkg::OUT_W-1:0];
		if (v < -hi - 1)
			return qrs_pkg::OUT_W'(-hi - 1);
		return v[qrs_pkg::OUT_W-1:0];
	endfunction

	function automatic logic signed [qrs_pkg::OUT_W-1:0] fixed_quot(longint num, longint den);
		return clamp_out((num * (64'sd1 <<< FB)) / den);
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint r;
		r = longint'($sqrt(real'(v)));
		while (r * r > v)
			r--;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	function automatic roots_t solve_roots(coeffs_t t);
		roots_t r;
		longint a, b, c, disc, s;
		a = t.a;
		b = t.b;
		c = t.c;
		r = '{default: '0, kind: qrs_pkg::KIND_A_ZERO};
		if (a == 0)
			return r;
		disc = b * b - 4 * a * c;
		s = floor_sqrt(disc < 0 ? -disc : disc);
		if (disc == 0) begin
			r.first_real = fixed_quot(-b, 2 * a);
			r.second_real = r.first_real;
			r.kind = qrs_pkg::KIND_EQUAL;
		end else if (disc > 0) begin
			r.first_real = fixed_quot(-b + s, 2 * a);
			r.second_real = fixed_quot(-b - s, 2 * a);
			r.kind = qrs_pkg::KIND_DISTINCT;
		end else begin
			r.first_real = fixed_quot(-b, 2 * a);
			r.second_real = r.first_real;
			r.first_imag = fixed_quot(s, 2 * a);
			r.second_imag = fixed_quot(-s, 2 * a);
			r.kind = qrs_pkg::KIND_COMPLEX;
		end
		return r;
	endfunction

	always @(posedge clk)
		in_taken <= s_tvalid && s_tready;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (pending_coeffs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= IN_W'(pending_coeffs[0]);
				s_tvalid <= 1'b1;
				expected_roots.push_back(solve_roots(pending_coeffs.pop_front()));
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= !hold_off && $urandom_range(99) >= recv_stall_pct;
	end

	always @(posedge clk) begin
		roots_t exp_r;
		logic signed [qrs_pkg::OUT_W-1:0] got [4];
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (m_tvalid && m_tready) begin
				for (int i = 0; i < 4; i++)
					got[i] = m_tdata[i*qrs_pkg::OUT_W +: qrs_pkg::OUT_W];
				if (expected_roots.size() == 0) begin
					$error("result with no expectation waiting");
					errors++;
				end else begin
					exp_r = expected_roots.pop_front();
					if (got[0] !== exp_r.first_real) begin
						$error("first_real exp %0d got %0d", exp_r.first_real, got[0]);
						errors++;
					end
					if (got[1] !== exp_r.first_imag) begin
						$error("first_imag exp %0d got %0d", exp_r.first_imag, got[1]);
						errors++;
					end
					if (got[2] !== exp_r.second_real) begin
						$error("second_real exp %0d got %0d", exp_r.second_real, got[2]);
						errors++;
					end
					if (got[3] !== exp_r.second_imag) begin
						$error("second_imag exp %0d got %0d", exp_r.second_imag, got[3]);
						errors++;
					end
					if (m_tuser !== exp_r.kind) begin
						$error("root_kind exp %0d got %0d", exp_r.kind, m_tuser);
						errors++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_quadratic_root_solver NOT OK");
				$finish;
			end
		end
	end

	function automatic coeffs_t random_coeffs();
		coeffs_t t;
		int mode;
		int k;
		mode = $urandom_range(9);
		t = coeffs_t'({$urandom(), $urandom()});
		t.a = CW'($urandom());
		if (mode < 3) begin
			t.a = CW'($signed($urandom_range(16)) - 8);
			t.b = CW'($signed($urandom_range(64)) - 32);
			t.c = CW'($signed($urandom_range(64)) - 32);
		end else if (mode == 3) begin
			k = int'($urandom_range(60)) - 30;
			t.a = CW'($signed($urandom_range(16)) - 8);
			t.b = CW'(2 * t.a * k);
			t.c = CW'(t.a * k * k);
		end else if (mode == 4) begin
			t.a = '0;
		end
		return t;
	endfunction

	task automatic run_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n)
			pending_coeffs.push_back(random_coeffs());
		wait (pending_coeffs.size() == 0 && expected_roots.size() == 0);
	endtask

	localparam logic signed [CW-1:0] MAXV = 16'sh7fff;
	localparam logic signed [CW-1:0] MINV = -16'sh8000;

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		pending_coeffs = '{
			'{a: 0, b: 5, c: 3}, '{a: 1, b: -2, c: 1}, '{a: 1, b: 0, c: -4},
			'{a: 1, b: 0, c: 1}, '{a: -1, b: 0, c: 1}, '{a: -2, b: 1, c: -3},
			'{a: 1, b: 1, c: -1}, '{a: 1, b: MAXV, c: 0}, '{a: 1, b: MINV, c: MAXV},
			'{a: MAXV, b: MAXV, c: MAXV}, '{a: MINV, b: MINV, c: MINV},
			'{a: MINV, b: MAXV, c: MAXV}, '{a: MAXV, b: MINV, c: MINV},
			'{a: -1, b: MINV, c: MAXV}, '{a: 1, b: 0, c: MINV}, '{a: -1, b: 0, c: MINV},
			'{a: 1, b: MINV, c: 0}, '{a: -1, b: MAXV, c: MINV}, '{a: 3, b: 6, c: 3},
			'{a: -16'sd1, b: -16'sd1, c: -16'sd1}, '{a: 0, b: MINV, c: MAXV}
		};
		wait (pending_coeffs.size() == 0 && expected_roots.size() == 0);
		run_phase(350, 0, 0);
		run_phase(250, 88, 0);
		run_phase(250, 0, 88);
		run_phase(300, 30, 30);
		hold_off = 1'b1;
		repeat (200)
			pending_coeffs.push_back(random_coeffs());
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
		wait (pending_coeffs.size() == 0 && expected_roots.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_quadratic_root_solver OK");
		else
			$display("tb_quadratic_root_solver NOT OK");
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/qrs_pkg.sv
rtl/core/quadratic_root_solver.sv
rtl/core/qrs_checker.sv
test/tb_quadratic_root_solver.sv
